/* src/csu_pkg.sv */
// Shared types and constants for the counting semaphore unit.
// No dependencies; imported by every module of the block.
package csu_pkg;

    typedef logic [1:0] func_t;
    typedef logic [3:0] sem_id_t;
    typedef logic [2:0] task_id_t;
    typedef logic [7:0] count_t;
    typedef logic [7:0] wake_t;

    localparam func_t FUNC_POST     = 2'd0;
    localparam func_t FUNC_TRY_WAIT = 2'd1;
    localparam func_t FUNC_WAIT     = 2'd2;
    localparam func_t FUNC_UNUSED   = 2'd3;

    // Waiter table code for a task that waits on no semaphore.
    localparam sem_id_t SEM_NONE = 4'd15;

    localparam count_t COUNT_MAX = 8'hFF;
    localparam count_t COUNT_ONE = 8'h01;

    // Count bank command: update the addressed count by one, down if dec.
    typedef struct packed {
        logic upd;
        logic dec;
    } cnt_cmd_t;

    // Waiter table command: record a waiter, start or advance a release scan.
    typedef struct packed {
        logic record;
        logic start;
        logic step;
    } wt_cmd_t;

    // Waiter table status back to the sequencer.
    typedef struct packed {
        logic  last;
        wake_t wake;
    } wt_stat_t;

endpackage

/* src/csu_counts.sv */
// Semaphore count bank with its shared increment/decrement adder.
// Depends on csu_pkg.
module csu_counts #(
    parameter int NUM_SEMS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  csu_pkg::sem_id_t  sid,
    input  csu_pkg::cnt_cmd_t cmd,
    output csu_pkg::count_t   count
);
    import csu_pkg::*;

    localparam int SIDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

    count_t counts_reg [NUM_SEMS];
    count_t sum;

    // The caller only uses the read value for an id that is in range.
    assign count = counts_reg[sid[SIDX_W-1:0]];
    assign sum   = count + (cmd.dec ? COUNT_MAX : COUNT_ONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SEMS; s++)
            begin
                counts_reg[s] <= '0;
            end
        end
        else
        begin
            for (int s = 0; s < NUM_SEMS; s++)
            begin
                if (cmd.upd && sid == 4'(s))
                begin
                    counts_reg[s] <= sum;
                end
            end
        end
    end

endmodule

/* src/csu_waiters.sv */
// Waiter table with a single comparator that scans one task per cycle
// when a post releases waiters. Depends on csu_pkg.
module csu_waiters #(
    parameter int NUM_TASKS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  csu_pkg::wt_cmd_t  cmd,
    input  csu_pkg::sem_id_t  sid,
    input  csu_pkg::task_id_t tid,
    output csu_pkg::wt_stat_t stat
);
    import csu_pkg::*;

    localparam int TIDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    sem_id_t           waiting_reg [NUM_TASKS];
    logic [TIDX_W-1:0] idx_reg;
    logic [TIDX_W-1:0] idx_next;
    wake_t             wake_reg;
    wake_t             wake_next;
    logic              hit;
    logic              last;
    logic [5:0]        idx_ext;

    assign idx_ext = 6'(idx_reg);
    assign hit     = cmd.step && (waiting_reg[idx_reg] == sid);
    assign last    = idx_reg == TIDX_W'(NUM_TASKS - 1);

    always_comb
    begin
        idx_next  = idx_reg;
        wake_next = wake_reg;
        if (cmd.start)
        begin
            idx_next  = '0;
            wake_next = '0;
        end
        else if (cmd.step)
        begin
            if (!last)
            begin
                idx_next = idx_reg + TIDX_W'(1);
            end
            for (int i = 0; i < 8; i++)
            begin
                if (hit && idx_ext == 6'(i))
                begin
                    wake_next[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            wake_reg <= '0;
            for (int t = 0; t < NUM_TASKS; t++)
            begin
                waiting_reg[t] <= SEM_NONE;
            end
        end
        else
        begin
            idx_reg  <= idx_next;
            wake_reg <= wake_next;
            for (int t = 0; t < NUM_TASKS; t++)
            begin
                if (cmd.record && {3'b000, tid} == 6'(t))
                begin
                    waiting_reg[t] <= sid;
                end
                else if (hit && idx_ext == 6'(t))
                begin
                    waiting_reg[t] <= SEM_NONE;
                end
            end
        end
    end

    assign stat.last = last;
    assign stat.wake = wake_reg;

endmodule

/* src/counting_semaphore_unit.sv */
// Top level of the counting semaphore unit: request sequencer and result
// register. Depends on csu_pkg, csu_counts and csu_waiters.
//
//   channel   handshake              payload
//   request   in_valid / in_ready    func, sem_id, task_id
//   result    out_valid / out_ready  acquired, blocked, wake_mask, bad_id, overflow
//
// A request is taken only while the sequencer is idle. The cycle after the
// transaction the addressed count is read and updated; a request then ends
// in the result stage. A post that finds a zero count first walks the
// waiter table with one comparator, one task per cycle. The result register
// lets a new request be taken while the previous result waits; a stalled
// result holds the sequencer in its result stage. Reset clears all counts
// and marks every task as waiting on nothing; no clearing pass follows it.
module counting_semaphore_unit #(
    parameter int NUM_SEMS  = 8,
    parameter int NUM_TASKS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  csu_pkg::func_t    func,
    input  csu_pkg::sem_id_t  sem_id,
    input  csu_pkg::task_id_t task_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              acquired,
    output logic              blocked,
    output csu_pkg::wake_t    wake_mask,
    output logic              bad_id,
    output logic              overflow
);
    import csu_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Captured request.
    func_t    func_reg;
    sem_id_t  sid_reg;
    task_id_t tid_reg;

    // Result being built.
    logic acq_reg, acq_next;
    logic blk_reg, blk_next;
    logic bad_reg, bad_next;
    logic ovf_reg, ovf_next;
    logic woke_reg, woke_next;

    // Output register.
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  o_acq_reg, o_blk_reg, o_bad_reg, o_ovf_reg;
    wake_t o_wake_reg;

    cnt_cmd_t cnt_cmd;
    count_t   cnt_value;
    wt_cmd_t  wt_cmd;
    wt_stat_t wt_stat;

    logic in_take;
    logic out_load;
    logic sid_ok;
    logic tid_ok;
    logic cnt_zero;
    logic cnt_full;
    logic is_post;
    logic is_take;
    logic op_valid;

    csu_counts #(
        .NUM_SEMS (NUM_SEMS)
    ) u_counts (
        .clk   (clk),
        .rst_n (rst_n),
        .sid   (sid_reg),
        .cmd   (cnt_cmd),
        .count (cnt_value)
    );

    csu_waiters #(
        .NUM_TASKS (NUM_TASKS)
    ) u_waiters (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (wt_cmd),
        .sid   (sid_reg),
        .tid   (tid_reg),
        .stat  (wt_stat)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_take  = in_valid && in_ready;
    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);

    // Decode of the captured request, valid during the check cycle.
    assign op_valid = (func_reg != FUNC_UNUSED);
    assign sid_ok   = (sid_reg < 4'(NUM_SEMS));
    assign tid_ok   = ({3'b000, tid_reg} < 6'(NUM_TASKS));
    assign cnt_zero = (cnt_value == '0);
    assign cnt_full = (cnt_value == COUNT_MAX);
    assign is_post  = (func_reg == FUNC_POST);
    assign is_take  = (func_reg == FUNC_TRY_WAIT) || (func_reg == FUNC_WAIT);

    always_comb
    begin
        cnt_cmd.upd = (state_reg == ST_CHECK) && op_valid && sid_ok
                      && ((is_post && !cnt_full) || (is_take && !cnt_zero));
        cnt_cmd.dec = !is_post;

        // A wait on an empty semaphore is recorded only for a task that
        // exists in the table; it still reports blocked otherwise.
        wt_cmd.record = (state_reg == ST_CHECK) && sid_ok
                        && (func_reg == FUNC_WAIT) && cnt_zero && tid_ok;
        wt_cmd.start  = (state_reg == ST_CHECK) && sid_ok && is_post && cnt_zero;
        wt_cmd.step   = (state_reg == ST_SCAN);
    end

    always_comb
    begin
        state_next = state_reg;
        acq_next   = acq_reg;
        blk_next   = blk_reg;
        bad_next   = bad_reg;
        ovf_next   = ovf_reg;
        woke_next  = woke_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                acq_next   = 1'b0;
                blk_next   = 1'b0;
                bad_next   = 1'b0;
                ovf_next   = 1'b0;
                woke_next  = 1'b0;
                state_next = ST_RESULT;
                priority if (!op_valid)
                begin
                    // Unused operation code: every field stays clear.
                end
                else if (!sid_ok)
                begin
                    bad_next = 1'b1;
                end
                else if (is_post)
                begin
                    ovf_next = cnt_full;
                    if (cnt_zero)
                    begin
                        woke_next  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    acq_next = !cnt_zero;
                    blk_next = cnt_zero && (func_reg == FUNC_WAIT);
                end
            end
            ST_SCAN:
            begin
                if (wt_stat.last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= func;
            sid_reg  <= sem_id;
            tid_reg  <= task_id;
        end
        acq_reg  <= acq_next;
        blk_reg  <= blk_next;
        bad_reg  <= bad_next;
        ovf_reg  <= ovf_next;
        woke_reg <= woke_next;
        if (out_load)
        begin
            o_acq_reg  <= acq_reg;
            o_blk_reg  <= blk_reg;
            o_bad_reg  <= bad_reg;
            o_ovf_reg  <= ovf_reg;
            o_wake_reg <= woke_reg ? wt_stat.wake : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign acquired  = o_acq_reg;
    assign blocked   = o_blk_reg;
    assign bad_id    = o_bad_reg;
    assign overflow  = o_ovf_reg;
    assign wake_mask = o_wake_reg;

`ifndef SYNTHESIS
    // A result reports at most one of its outcome flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({acquired, blocked, bad_id, overflow}) <= 1)
        else $error("more than one outcome flag in a result");

    // Waiters are only released by a post that took no unit and was valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && wake_mask != '0) |-> (!acquired && !blocked && !bad_id && !overflow))
        else $error("wake mask alongside another outcome");

    // A taken request is checked in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_CHECK))
        else $error("accepted request not checked");

    // The table scan only ends in the result stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (state_reg == ST_SCAN || state_reg == ST_RESULT))
        else $error("scan left for a wrong state");

    // Nothing may update a count or record a waiter during the scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !cnt_cmd.upd && !wt_cmd.record)
        else $error("state written during waiter scan");
`endif

endmodule

/* tb/csu_semaphore_check.sv */
`timescale 1ns / 1ps
// Checker for the counting semaphore unit: keeps its own counts and waiter
// table, predicts the outcome of every request and compares each result.
// Depends on csu_pkg; instantiated by the testbench beside the unit.
module csu_semaphore_check #(
    parameter int NUM_SEMS  = 8,
    parameter int NUM_TASKS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  csu_pkg::func_t    func,
    input  csu_pkg::sem_id_t  sem_id,
    input  csu_pkg::task_id_t task_id,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              acquired,
    input  logic              blocked,
    input  csu_pkg::wake_t    wake_mask,
    input  logic              bad_id,
    input  logic              overflow,
    output int                outstanding,
    output int                fail_count
);
    import csu_pkg::*;

    typedef struct packed {
        logic  acquired;
        logic  blocked;
        wake_t wake_mask;
        logic  bad_id;
        logic  overflow;
    } outcome_t;

    count_t   sem_level [NUM_SEMS];
    sem_id_t  waits_on [NUM_TASKS];
    outcome_t pending_outcomes [$];
    int       errors = 0;

    // Applies one request to the local copy of the bank and returns its outcome.
    function automatic outcome_t apply_request(func_t op, sem_id_t sid, task_id_t tid);
        outcome_t res;
        int       s;
        int       k;
        res = '0;
        s   = int'(sid);
        k   = int'(tid);
        if (op != FUNC_UNUSED)
        begin
            if (s >= NUM_SEMS)
            begin
                res.bad_id = 1'b1;
            end
            else if (op == FUNC_POST)
            begin
                if (sem_level[s] == '0)
                begin
                    for (int t = 0; t < NUM_TASKS; t++)
                    begin
                        if (waits_on[t] == sid)
                        begin
                            waits_on[t] = SEM_NONE;
                            if (t < $bits(wake_t))
                            begin
                                res.wake_mask[t] = 1'b1;
                            end
                        end
                    end
                end
                if (sem_level[s] == COUNT_MAX)
                begin
                    res.overflow = 1'b1;
                end
                else
                begin
                    sem_level[s] = sem_level[s] + COUNT_ONE;
                end
            end
            else if (sem_level[s] != '0)
            begin
                sem_level[s] = sem_level[s] - COUNT_ONE;
                res.acquired = 1'b1;
            end
            else if (op == FUNC_WAIT)
            begin
                res.blocked = 1'b1;
                if (k < NUM_TASKS)
                begin
                    waits_on[k] = sid;
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SEMS; s++)
            begin
                sem_level[s] = '0;
            end
            for (int t = 0; t < NUM_TASKS; t++)
            begin
                waits_on[t] = SEM_NONE;
            end
            pending_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            // The oldest outcome is retired before a new request is queued.
            if (out_valid && out_ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: result with no request outstanding", $time);
                    errors++;
                end
                else
                begin
                    want           = pending_outcomes.pop_front();
                    got.acquired   = acquired;
                    got.blocked    = blocked;
                    got.wake_mask  = wake_mask;
                    got.bad_id     = bad_id;
                    got.overflow   = overflow;
                    if (got != want)
                    begin
                        $display("%0t: mismatch, expected acq %0b blk %0b wake 0x%02h bad %0b ovf %0b",
                                 $time, want.acquired, want.blocked, want.wake_mask,
                                 want.bad_id, want.overflow);
                        $display("%0t:           got acq %0b blk %0b wake 0x%02h bad %0b ovf %0b",
                                 $time, got.acquired, got.blocked, got.wake_mask,
                                 got.bad_id, got.overflow);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pending_outcomes.push_back(apply_request(func, sem_id, task_id));
            end
            outstanding <= pending_outcomes.size();
        end
        fail_count <= errors;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the counting semaphore unit testbench: clock, reset, request and
// result traffic and the verdict. Depends on csu_pkg, the unit and csu_semaphore_check.
module testbench;

    import csu_pkg::*;

    localparam int NUM_SEMS     = 8;
    localparam int NUM_TASKS    = 8;
    // Watchdog limit for a run of roughly 400 requests.
    localparam int CYCLE_LIMIT  = 200000;
    // Long enough for the result register and the sequencer both to fill.
    localparam int HOLD_CYCLES  = 60;
    // Long enough for a post with a waiter scan to finish.
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 28;
    localparam int FILL_POSTS   = 262;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    func_t    func;
    sem_id_t  sem_id;
    task_id_t task_id;
    logic     out_valid;
    logic     out_ready;
    logic     acquired;
    logic     blocked;
    wake_t    wake_mask;
    logic     bad_id;
    logic     overflow;

    int outstanding;
    int fail_count;
    int cycle_count = 0;

    // Shared with the result-side process: how often it stalls, and a request
    // for one long hold-off.
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    int hold_left = 0;

    always #5 clk = ~clk;

    counting_semaphore_unit #(
        .NUM_SEMS  (NUM_SEMS),
        .NUM_TASKS (NUM_TASKS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .sem_id    (sem_id),
        .task_id   (task_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .acquired  (acquired),
        .blocked   (blocked),
        .wake_mask (wake_mask),
        .bad_id    (bad_id),
        .overflow  (overflow)
    );

    csu_semaphore_check #(
        .NUM_SEMS  (NUM_SEMS),
        .NUM_TASKS (NUM_TASKS)
    ) sem_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .sem_id      (sem_id),
        .task_id     (task_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .acquired    (acquired),
        .blocked     (blocked),
        .wake_mask   (wake_mask),
        .bad_id      (bad_id),
        .overflow    (overflow),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // Watchdog: a hung handshake ends the run here rather than never.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side. Ready is redrawn every cycle against stall_pct, except
    // during a requested hold-off, which is counted down here so that the
    // request side keeps offering transactions meanwhile.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= (int'($urandom_range(99)) >= stall_pct);
            end
        end
    end

    // Offers one request and returns at the edge where the transaction takes
    // place. Valid is left high, so a caller that sends straight away keeps
    // it high without a glitch.
    task automatic send_request(func_t op, sem_id_t sid, task_id_t tid);
        in_valid <= 1'b1;
        func     <= op;
        sem_id   <= sid;
        task_id  <= tid;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Idle cycles on the request side, each drawn with the given percentage.
    task automatic idle_gap(int gap_pct);
        while (int'($urandom_range(99)) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stops offering and waits until every outstanding result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Mostly valid requests on a handful of semaphores, so that counts stay
    // low and waits block often enough for posts to release waiters. One in
    // ten is the unused operation or an out-of-range id.
    task automatic send_random(int gap_pct);
        int      pick;
        int      op_roll;
        func_t   op;
        sem_id_t sid;
        pick    = int'($urandom_range(99));
        op_roll = int'($urandom_range(99));
        op      = (op_roll < 40) ? FUNC_POST : (op_roll < 60) ? FUNC_TRY_WAIT : FUNC_WAIT;
        if (pick < 3)
        begin
            op  = FUNC_UNUSED;
            sid = sem_id_t'($urandom_range(15));
        end
        else if (pick < 10)
        begin
            sid = sem_id_t'($urandom_range(15, NUM_SEMS));
        end
        else if ($urandom_range(9) < 7)
        begin
            sid = sem_id_t'($urandom_range(3));
        end
        else
        begin
            sid = sem_id_t'($urandom_range(NUM_SEMS - 1));
        end
        idle_gap(gap_pct);
        send_request(op, sid, task_id_t'($urandom_range(7)));
    endtask

    task automatic run_phase(int items, int gap_pct, int stall);
        stall_pct = stall;
        repeat (items)
        begin
            send_random(gap_pct);
        end
        wait_drained();
    endtask

    initial
    begin
        sem_id_t fill_sem;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        func     = FUNC_POST;
        sem_id   = '0;
        task_id  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The unused operation and out-of-range ids come
        // first, the first of them with every input bit set; they must leave the bank alone.
        send_request(FUNC_UNUSED, 4'd15, 3'd7);
        send_request(FUNC_POST, 4'd8, 3'd0);
        send_request(FUNC_TRY_WAIT, 4'd15, 3'd5);
        send_request(FUNC_WAIT, 4'd9, 3'd2);
        send_request(FUNC_UNUSED, 4'd0, 3'd0);
        // A try_wait on an empty semaphore neither takes a unit nor blocks,
        // and a post with nobody waiting wakes nobody.
        send_request(FUNC_TRY_WAIT, 4'd0, 3'd0);
        send_request(FUNC_POST, 4'd2, 3'd0);
        // Build up waiters; task 3 then waits again elsewhere, which must
        // replace its earlier entry, so the post on semaphore 1 wakes nobody.
        send_request(FUNC_WAIT, 4'd0, 3'd0);
        send_request(FUNC_WAIT, 4'd0, 3'd7);
        send_request(FUNC_WAIT, 4'd1, 3'd3);
        send_request(FUNC_WAIT, 4'd0, 3'd3);
        send_request(FUNC_WAIT, 4'd7, 3'd5);
        send_request(FUNC_WAIT, 4'd6, 3'd6);
        send_request(FUNC_POST, 4'd1, 3'd0);
        // Releases tasks 0, 3 and 7 together; the second post finds a
        // nonzero count and releases nobody.
        send_request(FUNC_POST, 4'd0, 3'd0);
        send_request(FUNC_POST, 4'd0, 3'd1);
        send_request(FUNC_TRY_WAIT, 4'd0, 3'd1);
        send_request(FUNC_WAIT, 4'd0, 3'd2);
        send_request(FUNC_WAIT, 4'd0, 3'd4);
        send_request(FUNC_POST, 4'd7, 3'd6);
        send_request(FUNC_POST, 4'd6, 3'd1);
        send_request(FUNC_POST, 4'd0, 3'd2);
        send_request(FUNC_TRY_WAIT, 4'd2, 3'd6);
        send_request(FUNC_WAIT, 4'd1, 3'd1);
        wait_drained();

        // No idling, but one long hold-off on the result side so that the
        // unit backs up and drops in_ready while requests keep coming.
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS, 0, 0);
        run_phase(PHASE_ITEMS, 59, 0);
        run_phase(PHASE_ITEMS, 0, 59);
        run_phase(PHASE_ITEMS, 30, 30);

        // Drive one semaphore to full count and past it: the last few posts
        // must saturate and flag overflow. Then take units back off it.
        stall_pct = 0;
        fill_sem  = sem_id_t'($urandom_range(NUM_SEMS - 1));
        repeat (FILL_POSTS)
        begin
            send_request(FUNC_POST, fill_sem, task_id_t'($urandom_range(7)));
        end
        send_request(FUNC_WAIT, fill_sem, task_id_t'($urandom_range(7)));
        send_request(FUNC_TRY_WAIT, fill_sem, task_id_t'($urandom_range(7)));
        send_request(FUNC_POST, fill_sem, task_id_t'($urandom_range(7)));
        wait_drained();

        // Let any late or spurious result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
